// ===== rtl/rrts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_pkg: shared types and constants of the round-robin thread scheduler
// Slot table geometry, operation and register codes, channel payloads,
// controller state encoding and controller/datapath command bundles.
// ----------------------------------------------------------------------------
package rrts_pkg;

	localparam int SLOTS   = 16;
	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int COUNT_W = $clog2(SLOTS + 1);
	localparam int DATA_W  = 64;
	localparam int CFG_IDX_W = 1;

	// operation codes
	localparam logic [1:0] OP_ADD_KERNEL = 2'd0;
	localparam logic [1:0] OP_ADD_USER   = 2'd1;
	localparam logic [1:0] OP_TICK       = 2'd2;
	localparam logic [1:0] OP_EXIT       = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SCHED_ENABLE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SPACE = 1'b1;

	typedef struct packed {
		logic [1:0]        op;
		logic [DATA_W-1:0] context_ptr;
		logic [DATA_W-1:0] addr_space;
		logic [DATA_W-1:0] stack_top_in;
		logic [DATA_W-1:0] owner_handle;
	} req_item_t;

	typedef struct packed {
		logic [SLOT_W-1:0]  new_slot;
		logic               add_ok;
		logic [DATA_W-1:0]  resume_context;
		logic               switched;
		logic [DATA_W-1:0]  space_out;
		logic               arm_stack;
		logic [DATA_W-1:0]  stack_top_out;
		logic [SLOT_W-1:0]  current_slot;
		logic [DATA_W-1:0]  current_owner;
		logic [COUNT_W-1:0] live_count;
		logic [DATA_W-1:0]  switch_total;
	} rsp_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_LOOKUP,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic execute;
		logic lookup;
	} ctrl_t;

	// datapath to controller
	typedef struct packed {
		logic will_switch;
	} status_t;

endpackage

// ===== rtl/rrts_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_req_if / rrts_rsp_if: valid/ready channels of the scheduler
// Request channel carries one operation, response channel one result.
// ----------------------------------------------------------------------------
interface rrts_req_if;
	logic                 valid;
	logic                 ready;
	rrts_pkg::req_item_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rrts_rsp_if;
	logic                 valid;
	logic                 ready;
	rrts_pkg::rsp_item_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/rrts_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rrts_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/rrts_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_ctrl: scheduler sequencer
// Steps one operation through capture, execute, switch lookup and result hold.
// ----------------------------------------------------------------------------
module rrts_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	input  rrts_pkg::status_t  status,
	output rrts_pkg::ctrl_t    ctrl
);

	rrts_pkg::state_t state_q;
	rrts_pkg::state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrts_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			rrts_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_next = rrts_pkg::ST_EXEC;
				end
			end
			rrts_pkg::ST_EXEC: begin
				// only a switch needs the incoming slot's table entries
				if (status.will_switch) begin
					state_next = rrts_pkg::ST_LOOKUP;
				end else begin
					state_next = rrts_pkg::ST_DONE;
				end
			end
			rrts_pkg::ST_LOOKUP: begin
				state_next = rrts_pkg::ST_DONE;
			end
			rrts_pkg::ST_DONE: begin
				if (rsp_ready) begin
					state_next = rrts_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = rrts_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req_ready    = 1'b0;
		rsp_valid    = 1'b0;
		ctrl.capture = 1'b0;
		ctrl.execute = 1'b0;
		ctrl.lookup  = 1'b0;
		case (state_q)
			rrts_pkg::ST_IDLE: begin
				req_ready    = 1'b1;
				ctrl.capture = req_valid;
			end
			rrts_pkg::ST_EXEC: begin
				ctrl.execute = 1'b1;
			end
			rrts_pkg::ST_LOOKUP: begin
				ctrl.lookup = 1'b1;
			end
			rrts_pkg::ST_DONE: begin
				rsp_valid = 1'b1;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

endmodule

// ===== rtl/rrts_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_datapath: slot table, live mask and round-robin selector
// Holds the per-slot tables in RAM, the live mask, running slot, counters,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
module rrts_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rrts_pkg::ctrl_t                     ctrl,
	output rrts_pkg::status_t                   status,
	input  rrts_pkg::req_item_t                 req_data,
	output rrts_pkg::rsp_item_t                 rsp_data,
	input  logic                                cfg_we,
	input  logic [rrts_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rrts_pkg::DATA_W-1:0]         cfg_wdata
);

	// captured request
	logic [1:0]                  op_q;
	logic [rrts_pkg::DATA_W-1:0] ctx_q;
	logic [rrts_pkg::DATA_W-1:0] aspace_q;
	logic [rrts_pkg::DATA_W-1:0] stack_q;
	logic [rrts_pkg::DATA_W-1:0] owner_q;

	// scheduler state
	logic [rrts_pkg::SLOTS-1:0]   live_q;
	logic [rrts_pkg::SLOT_W-1:0]  running_q;
	logic [rrts_pkg::COUNT_W-1:0] count_q;
	logic [rrts_pkg::DATA_W-1:0]  switch_cnt_q;
	logic [rrts_pkg::DATA_W-1:0]  cur_owner_q;
	logic                         sched_en_q;
	logic [rrts_pkg::DATA_W-1:0]  kspace_q;

	// result register
	logic [rrts_pkg::SLOT_W-1:0] new_slot_q;
	logic                        add_ok_q;
	logic [rrts_pkg::DATA_W-1:0] resume_q;
	logic                        switched_q;
	logic [rrts_pkg::DATA_W-1:0] space_q;
	logic                        arm_q;
	logic [rrts_pkg::DATA_W-1:0] stack_out_q;

	logic                        is_add;
	logic                        is_tick;
	logic                        is_exit;
	logic                        free_found;
	logic [rrts_pkg::SLOT_W-1:0] free_idx;
	logic [rrts_pkg::SLOT_W-1:0] next_idx;
	logic                        will_switch;
	logic                        do_add;
	logic                        save_ctx;
	logic                        do_exit;
	logic [rrts_pkg::DATA_W-1:0] add_space;
	logic [rrts_pkg::DATA_W-1:0] add_owner;

	logic [rrts_pkg::DATA_W-1:0] ctx_rd;
	logic [rrts_pkg::DATA_W-1:0] space_rd;
	logic [rrts_pkg::DATA_W-1:0] stack_rd;
	logic [rrts_pkg::DATA_W-1:0] owner_rd;
	logic [rrts_pkg::DATA_W-1:0] in_owner;
	logic [rrts_pkg::SLOT_W-1:0] ctx_waddr;

	assign is_add  = (op_q == rrts_pkg::OP_ADD_KERNEL) || (op_q == rrts_pkg::OP_ADD_USER);
	assign is_tick = (op_q == rrts_pkg::OP_TICK);
	assign is_exit = (op_q == rrts_pkg::OP_EXIT);

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = rrts_pkg::SLOTS - 1; i >= 0; i--) begin
			if (!live_q[i]) begin
				free_found = 1'b1;
				free_idx   = rrts_pkg::SLOT_W'(i);
			end
		end
	end

	// next live slot after the running one, wrapping back to itself
	always_comb begin
		next_idx = running_q;
		for (int k = rrts_pkg::SLOTS; k >= 1; k--) begin
			if (live_q[running_q + rrts_pkg::SLOT_W'(k)]) begin
				next_idx = running_q + rrts_pkg::SLOT_W'(k);
			end
		end
	end

	assign will_switch = is_tick && sched_en_q && !((next_idx == running_q) && live_q[running_q]);
	assign status.will_switch = will_switch;

	assign do_add   = ctrl.execute && is_add && free_found;
	assign save_ctx = ctrl.execute && is_tick && sched_en_q && live_q[running_q];
	assign do_exit  = ctrl.execute && is_exit && (running_q != '0);

	assign add_space = (op_q == rrts_pkg::OP_ADD_KERNEL) ? kspace_q : aspace_q;
	assign add_owner = (op_q == rrts_pkg::OP_ADD_KERNEL) ? '0 : owner_q;
	assign ctx_waddr = is_add ? free_idx : running_q;

	// slot 0 owner is never written and reads as zero
	assign in_owner = (running_q == '0) ? '0 : owner_rd;

	rrts_ram #(.WIDTH(rrts_pkg::DATA_W), .DEPTH(rrts_pkg::SLOTS)) u_ctx_ram (
		.clk   (clk),
		.we    (do_add || save_ctx),
		.waddr (ctx_waddr),
		.wdata (ctx_q),
		.re    (ctrl.execute),
		.raddr (next_idx),
		.rdata (ctx_rd)
	);

	rrts_ram #(.WIDTH(rrts_pkg::DATA_W), .DEPTH(rrts_pkg::SLOTS)) u_space_ram (
		.clk   (clk),
		.we    (do_add),
		.waddr (free_idx),
		.wdata (add_space),
		.re    (ctrl.execute),
		.raddr (next_idx),
		.rdata (space_rd)
	);

	rrts_ram #(.WIDTH(rrts_pkg::DATA_W), .DEPTH(rrts_pkg::SLOTS)) u_stack_ram (
		.clk   (clk),
		.we    (do_add),
		.waddr (free_idx),
		.wdata (stack_q),
		.re    (ctrl.execute),
		.raddr (next_idx),
		.rdata (stack_rd)
	);

	rrts_ram #(.WIDTH(rrts_pkg::DATA_W), .DEPTH(rrts_pkg::SLOTS)) u_owner_ram (
		.clk   (clk),
		.we    (do_add),
		.waddr (free_idx),
		.wdata (add_owner),
		.re    (ctrl.execute),
		.raddr (next_idx),
		.rdata (owner_rd)
	);

	// request capture
	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			op_q     <= req_data.op;
			ctx_q    <= req_data.context_ptr;
			aspace_q <= req_data.addr_space;
			stack_q  <= req_data.stack_top_in;
			owner_q  <= req_data.owner_handle;
		end
	end

	// configuration and scheduler state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sched_en_q   <= 1'b0;
			kspace_q     <= '0;
			live_q       <= rrts_pkg::SLOTS'(1);
			running_q    <= '0;
			count_q      <= rrts_pkg::COUNT_W'(1);
			switch_cnt_q <= '0;
			cur_owner_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					rrts_pkg::CFG_SCHED_ENABLE: sched_en_q <= cfg_wdata[0];
					rrts_pkg::CFG_KERNEL_SPACE: kspace_q <= cfg_wdata;
					default: sched_en_q <= sched_en_q;
				endcase
			end
			if (do_add) begin
				live_q[free_idx] <= 1'b1;
				count_q          <= count_q + rrts_pkg::COUNT_W'(1);
				// an add may refill the slot that exited but still runs
				if (free_idx == running_q) begin
					cur_owner_q <= add_owner;
				end
			end
			if (do_exit && live_q[running_q]) begin
				live_q[running_q] <= 1'b0;
				count_q           <= count_q - rrts_pkg::COUNT_W'(1);
			end
			if (ctrl.execute && will_switch) begin
				running_q    <= next_idx;
				switch_cnt_q <= switch_cnt_q + rrts_pkg::DATA_W'(1);
			end
			if (ctrl.lookup) begin
				cur_owner_q <= in_owner;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (ctrl.execute) begin
			new_slot_q  <= do_add ? free_idx : '0;
			add_ok_q    <= is_add && free_found;
			resume_q    <= ctx_q;
			switched_q  <= will_switch;
			space_q     <= '0;
			arm_q       <= 1'b0;
			stack_out_q <= '0;
		end
		if (ctrl.lookup) begin
			resume_q    <= ctx_rd;
			space_q     <= (running_q == '0) ? kspace_q : space_rd;
			arm_q       <= (in_owner != '0);
			stack_out_q <= (in_owner != '0) ? stack_rd : '0;
		end
	end

	assign rsp_data.new_slot       = new_slot_q;
	assign rsp_data.add_ok         = add_ok_q;
	assign rsp_data.resume_context = resume_q;
	assign rsp_data.switched       = switched_q;
	assign rsp_data.space_out      = space_q;
	assign rsp_data.arm_stack      = arm_q;
	assign rsp_data.stack_top_out  = stack_out_q;
	assign rsp_data.current_slot   = running_q;
	assign rsp_data.current_owner  = cur_owner_q;
	assign rsp_data.live_count     = count_q;
	assign rsp_data.switch_total   = switch_cnt_q;

endmodule

// ===== rtl/round_robin_thread_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler: thread slot table with round-robin selection
// Operations arrive on the request channel (add kernel thread, add user
// thread, tick, exit current); each gives exactly one result on the response
// channel. Configuration is a plain write port: index 0 is the scheduler
// enable, index 1 the kernel address space root; write only while idle.
// One operation is in flight at a time. After a request transfer the result
// is valid once the operation has passed the execute state, and for a tick
// that switches slots also the lookup state, since the incoming slot's table
// entries come out of the registered table read. The next request can be
// taken the cycle after the response transfer. While the receiver stalls the
// result is held and no request is taken. Reset leaves slot 0 live and
// running, owner zero, the switch count zero and the scheduler disabled; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler (
	input  logic                            clk,
	input  logic                            arst_n,
	rrts_req_if.sink                        request,
	rrts_rsp_if.source                      response,
	input  logic                            cfg_we,
	input  logic [rrts_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rrts_pkg::DATA_W-1:0]     cfg_wdata
);

	rrts_pkg::ctrl_t   ctrl;
	rrts_pkg::status_t status;

	rrts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (request.valid),
		.req_ready (request.ready),
		.rsp_valid (response.valid),
		.rsp_ready (response.ready),
		.status    (status),
		.ctrl      (ctrl)
	);

	rrts_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.status    (status),
		.req_data  (request.data),
		.rsp_data  (response.data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for round_robin_thread_scheduler
// Drives add, tick and exit operations over the request channel and checks
// every result field against a cycle-free scheduler predictor. Runs a
// directed part, then random phases that alternate sender and receiver
// idling, and reprograms the enable and kernel address space between phases.
// ----------------------------------------------------------------------------
module testbench;
	import rrts_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	class sched_scoreboard;
		bit                enable;
		logic [DATA_W-1:0] kernel_space;
		bit                live[SLOTS];
		logic [DATA_W-1:0] ctx_tab[SLOTS];
		logic [DATA_W-1:0] space_tab[SLOTS];
		logic [DATA_W-1:0] stack_tab[SLOTS];
		logic [DATA_W-1:0] owner_tab[SLOTS];
		int unsigned       running;
		logic [DATA_W-1:0] switches;
		rsp_item_t         expected_q[$];
		int                errors;

		function new();
			enable = 1'b0;
			kernel_space = '0;
			for (int i = 0; i < SLOTS; i++) begin
				live[i] = (i == 0);
				ctx_tab[i] = '0;
				space_tab[i] = '0;
				stack_tab[i] = '0;
				owner_tab[i] = '0;
			end
			running = 0;
			switches = '0;
			errors = 0;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
			if (idx == CFG_SCHED_ENABLE)
				enable = value[0];
			else if (idx == CFG_KERNEL_SPACE)
				kernel_space = value;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// advance the slot table by one accepted request and queue its result
		function void note_request(req_item_t req);
			rsp_item_t   res;
			int unsigned slot;
			int unsigned nxt;
			int unsigned count;
			bit          found;
			res = '0;
			res.resume_context = req.context_ptr;
			found = 1'b0;
			slot = 0;
			case (req.op)
				OP_ADD_KERNEL, OP_ADD_USER: begin
					for (int k = 0; k < SLOTS; k++)
						if (!found && !live[k]) begin
							slot = k;
							found = 1'b1;
						end
					if (found) begin
						ctx_tab[slot] = req.context_ptr;
						stack_tab[slot] = req.stack_top_in;
						if (req.op == OP_ADD_KERNEL) begin
							space_tab[slot] = kernel_space;
							owner_tab[slot] = '0;
						end else begin
							space_tab[slot] = req.addr_space;
							owner_tab[slot] = req.owner_handle;
						end
						live[slot] = 1'b1;
						res.new_slot = slot[SLOT_W-1:0];
						res.add_ok = 1'b1;
					end
				end
				OP_TICK: begin
					if (enable) begin
						if (live[running])
							ctx_tab[running] = req.context_ptr;
						// first live slot after the running one, wrapping back to it
						nxt = running;
						for (int k = 1; k <= SLOTS; k++)
							if (!found && live[(running + k) % SLOTS]) begin
								nxt = (running + k) % SLOTS;
								found = 1'b1;
							end
						if (nxt != running || !live[running]) begin
							running = nxt;
							switches = switches + 1;
							res.switched = 1'b1;
							res.space_out = (nxt == 0) ? kernel_space : space_tab[nxt];
							if (owner_tab[nxt] != '0) begin
								res.arm_stack = 1'b1;
								res.stack_top_out = stack_tab[nxt];
							end
							res.resume_context = ctx_tab[nxt];
						end
					end
				end
				default: begin
					if (running != 0)
						live[running] = 1'b0;
				end
			endcase
			count = 0;
			for (int k = 0; k < SLOTS; k++)
				if (live[k])
					count++;
			res.current_slot = running[SLOT_W-1:0];
			res.current_owner = owner_tab[running];
			res.live_count = count[COUNT_W-1:0];
			res.switch_total = switches;
			expected_q.push_back(res);
		endfunction

		function void compare_field(string field, logic [DATA_W-1:0] want,
				logic [DATA_W-1:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
					$time, field, want, got);
			end
		endfunction

		function void check_response(rsp_item_t got);
			rsp_item_t want;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: expected none, actual 0x%0h", $time, got);
				return;
			end
			want = expected_q.pop_front();
			compare_field("new_slot", want.new_slot, got.new_slot);
			compare_field("add_ok", want.add_ok, got.add_ok);
			compare_field("resume_context", want.resume_context, got.resume_context);
			compare_field("switched", want.switched, got.switched);
			compare_field("space_out", want.space_out, got.space_out);
			compare_field("arm_stack", want.arm_stack, got.arm_stack);
			compare_field("stack_top_out", want.stack_top_out, got.stack_top_out);
			compare_field("current_slot", want.current_slot, got.current_slot);
			compare_field("current_owner", want.current_owner, got.current_owner);
			compare_field("live_count", want.live_count, got.live_count);
			compare_field("switch_total", want.switch_total, got.switch_total);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0] cfg_wdata;
	int send_idle_pct;
	int recv_idle_pct;
	int cycle_count;

	rrts_req_if request_ch ();
	rrts_rsp_if response_ch ();

	sched_scoreboard sched = new();

	round_robin_thread_scheduler u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.request   (request_ch),
		.response  (response_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n)
			response_ch.ready <= 1'b0;
		else
			response_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (request_ch.valid && request_ch.ready)
			sched.note_request(request_ch.data);
		if (response_ch.valid && response_ch.ready)
			sched.check_response(response_ch.data);
	end

	// generous limit on the whole run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic logic [DATA_W-1:0] random_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic req_item_t make_item(logic [1:0] op, logic [DATA_W-1:0] ctx,
			logic [DATA_W-1:0] space, logic [DATA_W-1:0] stack,
			logic [DATA_W-1:0] owner);
		req_item_t item;
		item.op = op;
		item.context_ptr = ctx;
		item.addr_space = space;
		item.stack_top_in = stack;
		item.owner_handle = owner;
		return item;
	endfunction

	function automatic req_item_t random_item(int add_pct, int exit_pct);
		req_item_t item;
		int roll;
		roll = $urandom_range(0, 99);
		item = make_item(OP_TICK, random_word(), random_word(), random_word(),
			random_word());
		if (roll < add_pct)
			item.op = $urandom_range(0, 1) ? OP_ADD_USER : OP_ADD_KERNEL;
		else if (roll < add_pct + exit_pct)
			item.op = OP_EXIT;
		// plenty of unowned user threads as well
		if (item.op == OP_ADD_USER && $urandom_range(0, 3) == 0)
			item.owner_handle = '0;
		return item;
	endfunction

	task automatic send_item(input req_item_t item);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			request_ch.valid <= 1'b0;
			@(posedge clk);
		end
		request_ch.valid <= 1'b1;
		request_ch.data <= item;
		do
			@(posedge clk);
		while (!request_ch.ready);
	endtask

	task automatic wait_for_results();
		request_ch.valid <= 1'b0;
		@(posedge clk);
		while (sched.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		sched.write_register(idx, value);
	endtask

	task automatic run_random(int count, int add_pct, int exit_pct);
		repeat (count) send_item(random_item(add_pct, exit_pct));
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		request_ch.valid = 1'b0;
		request_ch.data = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_cfg(CFG_SCHED_ENABLE, 64'd1);
		write_cfg(CFG_KERNEL_SPACE, '1);

		// slot 0 alone: tick saves and echoes, exit is ignored
		send_item(make_item(OP_TICK, 64'h0123_4567_89ab_cdef, '0, '0, '0));
		send_item(make_item(OP_EXIT, random_word(), '0, '0, '0));
		send_item(make_item(OP_ADD_KERNEL, '1, '1, '1, '1));
		send_item(make_item(OP_ADD_USER, '0, '0, '0, '1));
		send_item(make_item(OP_ADD_USER, random_word(), '1, random_word(), '0));
		send_item(make_item(OP_TICK, random_word(), '0, '0, '0));
		send_item(make_item(OP_TICK, '0, '0, '0, '0));
		// freed slot is skipped and its context is not saved on the next tick
		send_item(make_item(OP_EXIT, random_word(), '0, '0, '0));
		send_item(make_item(OP_TICK, '1, '0, '0, '0));
		send_item(make_item(OP_ADD_USER, random_word(), random_word(), random_word(),
			random_word()));
		send_item(make_item(OP_TICK, random_word(), '0, '0, '0));
		// fill the table, last two adds hit a full table
		for (int i = 0; i < 14; i++)
			send_item(make_item((i % 2) ? OP_ADD_USER : OP_ADD_KERNEL, random_word(),
				random_word(), random_word(), random_word()));
		wait_for_results();

		// disabled scheduler echoes the context
		write_cfg(CFG_SCHED_ENABLE, 64'd0);
		send_item(make_item(OP_TICK, random_word(), '0, '0, '0));
		wait_for_results();

		write_cfg(CFG_SCHED_ENABLE, 64'd1);
		write_cfg(CFG_KERNEL_SPACE, {$urandom, $urandom});
		send_idle_pct = 32;
		recv_idle_pct = 63;
		run_random(220, 40, 20);
		wait_for_results();

		write_cfg(CFG_KERNEL_SPACE, '0);
		send_idle_pct = 63;
		recv_idle_pct = 32;
		run_random(220, 25, 35);
		wait_for_results();

		write_cfg(CFG_SCHED_ENABLE, 64'd0);
		write_cfg(CFG_KERNEL_SPACE, {$urandom, $urandom});
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(100, 35, 25);
		wait_for_results();

		write_cfg(CFG_SCHED_ENABLE, 64'd1);
		write_cfg(CFG_KERNEL_SPACE, {$urandom, $urandom});
		run_random(260, 35, 25);
		wait_for_results();

		if (sched.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
